// ===== rtl/bdh_pkg.sv =====
`default_nettype none

package bdh_pkg;

    localparam int BUTTON_COUNT = 9;
    localparam int COUNT_WIDTH  = 8;
    localparam int THR_WIDTH    = 8;
    localparam int TIME_WIDTH   = 32;
    localparam int QUERY_WIDTH  = 4;
    localparam int SHIFT_WIDTH  = 8;

    // Comparison width wide enough for both the counter and the threshold.
    localparam int CMP_WIDTH = (COUNT_WIDTH > THR_WIDTH) ? COUNT_WIDTH : THR_WIDTH;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX      = '1;
    localparam logic [THR_WIDTH-1:0]   THRESHOLD_INIT = THR_WIDTH'(4);

    typedef logic [COUNT_WIDTH-1:0] t_count;
    typedef logic [TIME_WIDTH-1:0]  t_time;

    // Per-button state as it stands after the current poll.
    typedef struct packed {
        logic  stable;
        t_time press_time;
    } t_lane_out;

endpackage

`default_nettype wire

// ===== rtl/bdh_if.sv =====
`default_nettype none

interface bdh_in_if
    import bdh_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [SHIFT_WIDTH-1:0] shift_bits;
    logic                   start_level;
    logic [TIME_WIDTH-1:0]  now_ms;
    logic [QUERY_WIDTH-1:0] query_index;

    modport source (output valid, shift_bits, start_level, now_ms, query_index,
                    input ready);
    modport sink (input valid, shift_bits, start_level, now_ms, query_index,
                  output ready);
endinterface

interface bdh_out_if
    import bdh_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [BUTTON_COUNT-1:0] stable_buttons;
    logic [TIME_WIDTH-1:0]   hold_ms;

    modport source (output valid, stable_buttons, hold_ms, input ready);
    modport sink (input valid, stable_buttons, hold_ms, output ready);
endinterface

`default_nettype wire

// ===== rtl/bdh_lane.sv =====
`default_nettype none

module bdh_lane
    import bdh_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_raw_pressed,
    input  wire logic [THR_WIDTH-1:0] i_threshold,
    input  wire t_time                i_now,
    output t_lane_out                 o_next
);

    logic   r_cand, n_cand;
    logic   r_stable, n_stable;
    t_count r_count, n_count;
    t_time  r_press_time, n_press_time;

    always_comb begin
        n_cand       = r_cand;
        n_count      = r_count;
        n_stable     = r_stable;
        n_press_time = r_press_time;

        if (i_raw_pressed == r_cand) begin
            if (r_count != COUNT_MAX) begin
                n_count = r_count + COUNT_WIDTH'(1);
            end
        end else begin
            n_cand  = i_raw_pressed;
            n_count = '0;
        end

        if ((CMP_WIDTH'(n_count) >= CMP_WIDTH'(i_threshold)) && (n_cand != r_stable)) begin
            n_stable     = n_cand;
            n_press_time = n_cand ? i_now : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand       <= 1'b0;
            r_stable     <= 1'b0;
            r_count      <= '0;
            r_press_time <= '0;
        end else if (i_en) begin
            r_cand       <= n_cand;
            r_stable     <= n_stable;
            r_count      <= n_count;
            r_press_time <= n_press_time;
        end
    end

    // The merge stage needs the state as it stands after this poll.
    assign o_next.stable     = n_stable;
    assign o_next.press_time = n_press_time;

endmodule

`default_nettype wire

// ===== rtl/bdh_merge.sv =====
`default_nettype none

module bdh_merge
    import bdh_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_load,
    input  wire t_lane_out              i_lanes [BUTTON_COUNT],
    input  wire t_time                  i_now,
    input  wire logic [QUERY_WIDTH-1:0] i_query,
    input  wire logic                   i_out_ready,
    output logic                        o_valid,
    output logic [BUTTON_COUNT-1:0]     o_stable,
    output t_time                       o_hold
);

    logic                    r_valid, n_valid;
    logic [BUTTON_COUNT-1:0] r_stable, n_stable;
    t_time                   r_hold, n_hold;
    logic                    sel_stable;
    t_time                   sel_press;

    always_comb begin
        sel_stable = 1'b0;
        sel_press  = '0;
        for (int i = 0; i < BUTTON_COUNT; i++) begin
            n_stable[i] = i_lanes[i].stable;
            if (i_query == QUERY_WIDTH'(i)) begin
                sel_stable = i_lanes[i].stable;
                sel_press  = i_lanes[i].press_time;
            end
        end
        // An index beyond the last button matches no lane and reports zero.
        n_hold  = sel_stable ? (i_now - sel_press) : '0;
        n_valid = i_load | (r_valid & ~i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_stable <= n_stable;
            r_hold   <= n_hold;
        end
    end

    assign o_valid  = r_valid;
    assign o_stable = r_stable;
    assign o_hold   = r_hold;

endmodule

`default_nettype wire

// ===== rtl/button_debouncer_with_hold_timer.sv =====
`default_nettype none

// Debouncer for nine active-low buttons with a hold timer for each one.
// i_poll carries one poll: the shift-register byte (bit 7 is button 0), the
// start pin level (button 8), the millisecond time and a query index.
// o_result carries the debounced pressed flags and the hold time of the
// queried button, zero when that button is released or the index is 9..15.
// i_cfg_we/i_cfg_data write the debounce threshold, in polls.
// Each button has a lane of its own; all nine update in parallel and a merge
// stage picks the queried lane and forms the hold time.
// A result is valid in the cycle after its poll transfer.
// Throughput is one poll per cycle while results are taken, set by the single output register.
// If the receiver stalls, the result is held and i_poll.ready stays low until
// it is taken; in the cycle it is taken a new poll may transfer.
// Reset clears all button state to released, empties the output register and
// sets the threshold to four.
module button_debouncer_with_hold_timer
    import bdh_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    bdh_in_if.sink                    i_poll,
    bdh_out_if.source                 o_result,
    input  wire logic                 i_cfg_we,
    input  wire logic [THR_WIDTH-1:0] i_cfg_data
);

    logic [THR_WIDTH-1:0]    r_threshold;
    logic                    accept;
    logic [BUTTON_COUNT-1:0] raw_pressed;
    t_lane_out               lanes [BUTTON_COUNT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_INIT;
        end else if (i_cfg_we) begin
            r_threshold <= i_cfg_data;
        end
    end

    assign i_poll.ready = ~o_result.valid | o_result.ready;
    assign accept       = i_poll.valid & i_poll.ready;

    always_comb begin
        for (int i = 0; i < SHIFT_WIDTH; i++) begin
            raw_pressed[i] = ~i_poll.shift_bits[SHIFT_WIDTH-1-i];
        end
        raw_pressed[BUTTON_COUNT-1] = ~i_poll.start_level;
    end

    for (genvar g = 0; g < BUTTON_COUNT; g++) begin : g_lane
        bdh_lane u_lane (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_en          (accept),
            .i_raw_pressed (raw_pressed[g]),
            .i_threshold   (r_threshold),
            .i_now         (i_poll.now_ms),
            .o_next        (lanes[g])
        );
    end

    bdh_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_lanes     (lanes),
        .i_now       (i_poll.now_ms),
        .i_query     (i_poll.query_index),
        .i_out_ready (o_result.ready),
        .o_valid     (o_result.valid),
        .o_stable    (o_result.stable_buttons),
        .o_hold      (o_result.hold_ms)
    );

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_result.valid)
        else $error("result valid straight after reset");

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_poll.valid && i_poll.ready |=> o_result.valid)
        else $error("poll transfer produced no result");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && !o_result.ready |-> !i_poll.ready)
        else $error("poll accepted while a result is stalled");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb
    import bdh_pkg::*;
();

    localparam int IDLE_LIMIT = 2000;

    typedef struct packed {
        logic [BUTTON_COUNT-1:0] stable_buttons;
        t_time                   hold_ms;
    } t_button_result;

    // Tracks the debounced state of every button and queues the result that
    // each accepted poll must produce.
    class debounce_scoreboard;
        logic [THR_WIDTH-1:0]    threshold;
        logic [BUTTON_COUNT-1:0] candidate;
        logic [BUTTON_COUNT-1:0] stable;
        t_count                  agree [BUTTON_COUNT];
        t_time                   pressed_at [BUTTON_COUNT];
        t_button_result          expected_results [$];
        int errors;
        int polls;
        int results;
        int presses;
        int releases;
        int far_queries;

        function new();
            threshold = THRESHOLD_INIT;
            candidate = '0;
            stable = '0;
            foreach (agree[i]) begin
                agree[i] = '0;
                pressed_at[i] = '0;
            end
            errors = 0;
            polls = 0;
            results = 0;
            presses = 0;
            releases = 0;
            far_queries = 0;
        endfunction

        function void set_threshold(logic [THR_WIDTH-1:0] value);
            threshold = value;
        endfunction

        function void flag(string what, logic [31:0] want, logic [31:0] got);
            errors++;
            if (errors <= 10) begin
                $display("[%0t] mismatch on %s: expected %0h, got %0h", $time, what, want, got);
            end
        endfunction

        function void note_poll(logic [SHIFT_WIDTH-1:0] bits, logic start, t_time now,
                                logic [QUERY_WIDTH-1:0] query);
            logic           raw;
            t_button_result want;
            polls++;
            for (int i = 0; i < BUTTON_COUNT; i++) begin
                // Pins are active low; the byte's top bit belongs to button 0.
                if (i < SHIFT_WIDTH) begin
                    raw = ~bits[SHIFT_WIDTH-1-i];
                end else begin
                    raw = ~start;
                end
                if (raw == candidate[i]) begin
                    if (agree[i] != COUNT_MAX) agree[i] = agree[i] + 1'b1;
                end else begin
                    candidate[i] = raw;
                    agree[i] = '0;
                end
                if (CMP_WIDTH'(agree[i]) >= CMP_WIDTH'(threshold) &&
                    candidate[i] != stable[i]) begin
                    stable[i] = candidate[i];
                    if (stable[i]) begin
                        pressed_at[i] = now;
                        presses++;
                    end else begin
                        pressed_at[i] = '0;
                        releases++;
                    end
                end
            end
            want.stable_buttons = stable;
            want.hold_ms = '0;
            if (query < BUTTON_COUNT) begin
                if (stable[query]) want.hold_ms = now - pressed_at[query];
            end else begin
                far_queries++;
            end
            expected_results.push_back(want);
        endfunction

        function void check_result(logic [BUTTON_COUNT-1:0] buttons, t_time hold);
            t_button_result want;
            if (expected_results.size() == 0) begin
                flag("result with nothing pending", '0, 32'(buttons));
            end else begin
                want = expected_results.pop_front();
                results++;
                if (buttons !== want.stable_buttons) begin
                    flag("stable_buttons", 32'(want.stable_buttons), 32'(buttons));
                end
                if (hold !== want.hold_ms) flag("hold_ms", want.hold_ms, hold);
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we;
    logic [THR_WIDTH-1:0] cfg_data;
    logic                 steady = 1'b0;
    t_time                now_cur;
    int                   idle_cycles = 0;
    int                   mid_thr;
    debounce_scoreboard   sb;

    bdh_in_if  poll_if ();
    bdh_out_if res_if ();

    button_debouncer_with_hold_timer DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_poll     (poll_if),
        .o_result   (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    always #6 clk = ~clk;

    // Mostly back-to-back, now and then a short pause, rarely a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_poll(input logic [SHIFT_WIDTH-1:0] bits, input logic start,
                             input t_time now, input logic [QUERY_WIDTH-1:0] query);
        int gap;
        poll_if.valid <= 1'b1;
        poll_if.shift_bits <= bits;
        poll_if.start_level <= start;
        poll_if.now_ms <= now;
        poll_if.query_index <= query;
        do @(posedge clk); while (!poll_if.ready);
        gap = pick_gap();
        if (gap > 0) begin
            poll_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Pin levels per button (1 means released) packed into the poll fields.
    task automatic send_random_poll(input logic [BUTTON_COUNT-1:0] levels);
        logic [SHIFT_WIDTH-1:0] bits;
        logic [QUERY_WIDTH-1:0] query;
        for (int i = 0; i < SHIFT_WIDTH; i++) bits[SHIFT_WIDTH-1-i] = levels[i];
        if ($urandom_range(0, 9) == 0) begin
            now_cur = $urandom;
        end else begin
            now_cur = now_cur + $urandom_range(0, 40);
        end
        if ($urandom_range(0, 99) < 85) begin
            query = QUERY_WIDTH'($urandom_range(0, BUTTON_COUNT - 1));
        end else begin
            query = QUERY_WIDTH'($urandom_range(BUTTON_COUNT, 15));
        end
        send_poll(bits, levels[BUTTON_COUNT-1], now_cur, query);
    endtask

    // A clock edge passes first so that a transfer on the edge just gone is
    // already queued by the monitor before the queue is examined.
    task automatic drain();
        poll_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_results.size() != 0) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [THR_WIDTH-1:0] value);
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_threshold(value);
    endtask

    // Well-formed runs hold a pattern long enough to settle, optionally after
    // a little contact bounce; broken runs are no longer than the threshold and may be noisy.
    task automatic run_phase(input logic [THR_WIDTH-1:0] thr, input int items);
        int                      sent;
        int                      len;
        int                      kind;
        logic [BUTTON_COUNT-1:0] target;
        drain();
        write_threshold(thr);
        sent = 0;
        while (sent < items) begin
            target = BUTTON_COUNT'($urandom);
            kind = $urandom_range(0, 99);
            if (kind < 5) begin
                send_random_poll(BUTTON_COUNT'($urandom));
                sent++;
            end else if (kind < 25) begin
                len = $urandom_range(1, (thr > 0) ? thr : 1);
                repeat (len) begin
                    if ($urandom_range(0, 3) == 0) begin
                        send_random_poll(target ^ BUTTON_COUNT'($urandom));
                    end else begin
                        send_random_poll(target);
                    end
                    sent++;
                end
            end else begin
                repeat ($urandom_range(0, 3)) begin
                    send_random_poll(target ^ BUTTON_COUNT'($urandom & $urandom));
                    sent++;
                end
                len = thr + $urandom_range(1, 5);
                repeat (len) begin
                    send_random_poll(target);
                    sent++;
                end
            end
        end
    endtask

    always @(posedge clk) begin
        if (rst_n) begin
            // Results are checked before the poll of the same edge is noted,
            // so a spurious result cannot pair with a fresh expectation.
            if (res_if.valid && res_if.ready) begin
                sb.check_result(res_if.stable_buttons, res_if.hold_ms);
            end
            if (poll_if.valid && poll_if.ready) begin
                sb.note_poll(poll_if.shift_bits, poll_if.start_level, poll_if.now_ms,
                             poll_if.query_index);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (poll_if.valid && poll_if.ready) || (res_if.valid && res_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog expired after %0d cycles without a transfer.", IDLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int stall;
        res_if.ready = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    initial begin
        poll_if.valid = 1'b0;
        poll_if.shift_bits = '1;
        poll_if.start_level = 1'b1;
        poll_if.now_ms = '0;
        poll_if.query_index = '0;
        cfg_we = 1'b0;
        cfg_data = '0;
        now_cur = '0;
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset threshold: a press settles at time zero and still counts as held.
        send_poll(8'hFF, 1'b1, 32'd0, 4'd0);
        send_poll(8'h00, 1'b0, 32'd0, 4'd0);
        send_poll(8'h00, 1'b0, 32'd0, 4'd8);
        send_poll(8'h00, 1'b0, 32'd0, 4'd3);
        send_poll(8'h00, 1'b0, 32'd0, 4'd9);
        send_poll(8'h00, 1'b0, 32'd0, 4'd15);
        send_poll(8'h00, 1'b0, 32'd0, 4'd8);
        send_poll(8'h00, 1'b0, 32'd7, 4'd0);
        // A single-poll bounce only restarts the candidate count.
        send_poll(8'h7F, 1'b0, 32'd9, 4'd0);
        send_poll(8'h00, 1'b0, 32'd10, 4'd0);
        for (int k = 0; k < 5; k++) begin
            send_poll(8'hFF, 1'b1, 32'hFFFF_FFF0 + k, QUERY_WIDTH'(k));
        end
        send_poll(8'hA5, 1'b1, 32'hFFFF_FFFF, 4'd8);

        // Zero threshold: the stable level follows on the same poll.
        drain();
        write_threshold(8'd0);
        send_poll(8'h0F, 1'b0, 32'hFFFF_FFFE, 4'd8);
        send_poll(8'h0F, 1'b0, 32'd3, 4'd8);
        send_poll(8'hF0, 1'b1, 32'd4, 4'd0);
        send_poll(8'hF0, 1'b1, 32'd6, 4'd4);
        send_poll(8'h5A, 1'b0, 32'h8000_0000, 4'd1);

        drain();
        write_threshold(8'd1);
        send_poll(8'h3C, 1'b1, 32'h8000_0001, 4'd2);
        send_poll(8'h3C, 1'b1, 32'h8000_0009, 4'd7);
        send_poll(8'hC3, 1'b0, 32'h8000_000A, 4'd0);

        now_cur = 32'h8000_0010;
        steady = 1'b1;
        run_phase(8'd2, 90);
        steady = 1'b0;
        mid_thr = $urandom_range(3, 10);
        run_phase(THR_WIDTH'(mid_thr), 120);
        run_phase(8'd0, 70);
        run_phase(8'd1, 70);
        run_phase(8'd255, 150);

        drain();
        repeat (5) @(posedge clk);
        $display("Covered %0d polls and %0d results at thresholds 4, 0, 1, 2, %0d and 255.",
                 sb.polls, sb.results, mid_thr);
        $display("Settled %0d presses and %0d releases; %0d hold queries were out of range.",
                 sb.presses, sb.releases, sb.far_queries);
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches in total.", sb.errors);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/bdh_pkg.sv
rtl/bdh_if.sv
rtl/bdh_lane.sv
rtl/bdh_merge.sv
rtl/button_debouncer_with_hold_timer.sv
dv/tb.sv
